@@ rtl/dte_pkg.sv @@
package dte_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DAYS_W  = 22;
    localparam int WDAY_W  = 3;
    localparam int YDAY_W  = 9;
    localparam int WSUM_W  = 15;

    localparam int EPOCH_YEAR_DEF = 1970;
    localparam int MAX_YEAR_DEF   = 9999;

    localparam int DAYS_PER_YEAR = 365;
    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_DATE     = 2'd1,
        ST_BEFORE_EPOCH = 2'd2
    } status_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [YDAY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] start;
        case (m)
            4'd1:    start = 9'd0;
            4'd2:    start = 9'd31;
            4'd3:    start = 9'd59;
            4'd4:    start = 9'd90;
            4'd5:    start = 9'd120;
            4'd6:    start = 9'd151;
            4'd7:    start = 9'd181;
            4'd8:    start = 9'd212;
            4'd9:    start = 9'd243;
            4'd10:   start = 9'd273;
            4'd11:   start = 9'd304;
            4'd12:   start = 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

@@ rtl/dte_mod7.sv @@
module dte_mod7 (
    input  logic [dte_pkg::WSUM_W-1:0] value,
    output logic [dte_pkg::WDAY_W-1:0] residue
);

    // 8 is 1 mod 7: fold octal digits
    logic [5:0] fold1;
    logic [3:0] fold2;

    always_comb
    begin
        fold1 = 6'(value[14:12]) + 6'(value[11:9]) + 6'(value[8:6])
              + 6'(value[5:3]) + 6'(value[2:0]);
        fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
        if (fold2 >= 4'd7)
        begin
            fold2 = fold2 - 4'd7;
        end
        residue = fold2[2:0];
    end

endmodule

@@ rtl/date_to_epoch_day.sv @@
// Converts a Gregorian date (year, month, day) into days since January 1 of
// EPOCH_YEAR, weekday (0 Sunday .. 6 Saturday), zero-based day of year and a
// leap flag, with status 1 for an invalid date or a year above MAX_YEAR and
// status 2 for a valid date before the epoch (other fields then zero). One
// date is taken every cycle while in_stall is low; each result leaves
// after four register stages. Stall on the output side backs up through
// the stage enables, and empty stages fill while the output is held, so
// in_stall rises only once all four are full.
module date_to_epoch_day #(
    parameter int EPOCH_YEAR = dte_pkg::EPOCH_YEAR_DEF,
    parameter int MAX_YEAR   = dte_pkg::MAX_YEAR_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dte_pkg::YEAR_W-1:0]  year,
    input  logic [dte_pkg::MONTH_W-1:0] month,
    input  logic [dte_pkg::DAY_W-1:0]   day,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [dte_pkg::DAYS_W-1:0]  epoch_days,
    output logic [dte_pkg::WDAY_W-1:0]  weekday,
    output logic [dte_pkg::YDAY_W-1:0]  year_day,
    output logic                        is_leap
);

    localparam int YW  = dte_pkg::YEAR_W;
    localparam int MW  = dte_pkg::MONTH_W;
    localparam int DW  = dte_pkg::DAY_W;
    localparam int YDW = dte_pkg::YDAY_W;
    localparam int SW  = dte_pkg::WSUM_W;
    localparam int QW  = 8;
    localparam int LW  = 12;
    localparam int PW  = YW + 13;
    localparam int AW  = 24;

    localparam int EpochPrev = EPOCH_YEAR - 1;
    localparam int EpochJan1 = EpochPrev * dte_pkg::DAYS_PER_YEAR + EpochPrev / 4
                             - EpochPrev / 100 + EpochPrev / 400;
    localparam logic [16:0] MaxYear   = 17'(MAX_YEAR);
    localparam logic [YW-1:0] EpochYr = YW'(EPOCH_YEAR);

    // stage enables, last stage first
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign en4      = !v4_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: year / 100, month table, range checks
    logic [PW-1:0]  q100_prod;
    logic [QW-1:0]  q100_next;
    logic           bad1_next;
    logic [YW-1:0]  year1_reg;
    logic [MW-1:0]  month1_reg;
    logic [DW-1:0]  day1_reg;
    logic [QW-1:0]  q100_reg;
    logic [DW-1:0]  mlen1_reg;
    logic [YDW-1:0] mstart1_reg;
    logic           bad1_reg;

    always_comb
    begin
        q100_prod = PW'(year) * PW'(dte_pkg::RECIP_100);
        q100_next = q100_prod[dte_pkg::RECIP_SHIFT +: QW];
        bad1_next = (day == '0) || (month < dte_pkg::MONTH_JAN)
                 || (month > dte_pkg::MONTH_DEC) || (17'(year) > MaxYear);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            year1_reg   <= year;
            month1_reg  <= month;
            day1_reg    <= day;
            q100_reg    <= q100_next;
            mlen1_reg   <= dte_pkg::month_len(month);
            mstart1_reg <= dte_pkg::month_start(month);
            bad1_reg    <= bad1_next;
        end
    end

    // stage 2: leap rule, day check, day of year, leap count up to year - 1
    logic [YW-1:0]  r100;
    logic           r100_zero;
    logic           leap_next;
    logic [DW-1:0]  mlen;
    logic [1:0]     status2_next;
    logic [YDW-1:0] yday2_next;
    logic [YW-1:0]  ym1_next;
    logic [QW-1:0]  q100m;
    logic [LW-1:0]  lcount_next;

    logic [1:0]     status2_reg;
    logic           leap2_reg;
    logic [YDW-1:0] yday2_reg;
    logic [YW-1:0]  ym1_reg;
    logic [LW-1:0]  lcount_reg;

    always_comb
    begin
        r100      = year1_reg - YW'(q100_reg * YW'(100));
        r100_zero = (r100 == '0);
        leap_next = ((year1_reg[1:0] == 2'b00) && !r100_zero)
                 || (r100_zero && (q100_reg[1:0] == 2'b00));
        mlen      = mlen1_reg;
        if ((month1_reg == dte_pkg::MONTH_FEB) && leap_next)
        begin
            mlen = 5'd29;
        end
        if (bad1_reg || (day1_reg > mlen))
        begin
            status2_next = dte_pkg::ST_BAD_DATE;
        end
        else if (year1_reg < EpochYr)
        begin
            status2_next = dte_pkg::ST_BEFORE_EPOCH;
        end
        else
        begin
            status2_next = dte_pkg::ST_OK;
        end
        yday2_next = mstart1_reg + YDW'(day1_reg) - YDW'(1)
                   + YDW'(leap_next && (month1_reg > dte_pkg::MONTH_FEB));
        ym1_next    = year1_reg - YW'(1);
        q100m       = q100_reg - QW'(r100_zero);
        lcount_next = LW'(ym1_next >> 2) - LW'(q100m) + LW'(q100m >> 2);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            status2_reg <= status2_next;
            leap2_reg   <= leap_next;
            yday2_reg   <= yday2_next;
            ym1_reg     <= ym1_next;
            lcount_reg  <= lcount_next;
        end
    end

    // stage 3: day count and weekday sum
    logic [22:0]    prod365;
    logic [AW-1:0]  days3_next;
    logic [SW-1:0]  wsum_next;

    logic [1:0]                 status3_reg;
    logic                       leap3_reg;
    logic [YDW-1:0]             yday3_reg;
    logic [dte_pkg::DAYS_W-1:0] days3_reg;
    logic [SW-1:0]              wsum_reg;

    always_comb
    begin
        prod365    = 23'(ym1_reg) * 23'(dte_pkg::DAYS_PER_YEAR);
        days3_next = AW'(prod365) + AW'(lcount_reg) + AW'(yday2_reg) - AW'(EpochJan1);
        // 365 is 1 mod 7 and 0001-01-01 is a Monday
        wsum_next  = SW'(ym1_reg) + SW'(lcount_reg) + SW'(yday2_reg) + SW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            status3_reg <= status2_reg;
            leap3_reg   <= leap2_reg;
            yday3_reg   <= yday2_reg;
            days3_reg   <= days3_next[dte_pkg::DAYS_W-1:0];
            wsum_reg    <= wsum_next;
        end
    end

    // stage 4: weekday residue, zero the fields of a failed date
    logic [dte_pkg::WDAY_W-1:0] wday;
    logic                       ok3;
    logic [1:0]                 status_reg;
    logic [dte_pkg::DAYS_W-1:0] days_reg;
    logic [dte_pkg::WDAY_W-1:0] wday_reg;
    logic [YDW-1:0]             yday_reg;
    logic                       leap_reg;

    dte_mod7 u_mod7 (
        .value   (wsum_reg),
        .residue (wday)
    );

    assign ok3 = (status3_reg == dte_pkg::ST_OK);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            status_reg <= status3_reg;
            days_reg   <= ok3 ? days3_reg : '0;
            wday_reg   <= ok3 ? wday : '0;
            yday_reg   <= ok3 ? yday3_reg : '0;
            leap_reg   <= ok3 && leap3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign status     = status_reg;
    assign epoch_days = days_reg;
    assign weekday    = wday_reg;
    assign year_day   = yday_reg;
    assign is_leap    = leap_reg;

endmodule

@@ rtl/dte_checks.sv @@
module dte_checks (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [1:0]                  status,
    input logic [dte_pkg::DAYS_W-1:0]  epoch_days,
    input logic [dte_pkg::WDAY_W-1:0]  weekday,
    input logic [dte_pkg::YDAY_W-1:0]  year_day,
    input logic                        is_leap
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(epoch_days))
        else $error("held word changed");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != dte_pkg::ST_OK)
        |-> (epoch_days == '0) && (weekday == '0) && (year_day == '0) && !is_leap)
        else $error("failed date carries nonzero fields");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3) && (weekday <= 3'd6))
        else $error("status or weekday out of range");

    a_yday: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dte_pkg::ST_OK)
        |-> (year_day <= 9'(364) + 9'(is_leap)))
        else $error("day of year beyond year length");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

endmodule

bind date_to_epoch_day dte_checks u_dte_checks (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .epoch_days (epoch_days),
    .weekday    (weekday),
    .year_day   (year_day),
    .is_leap    (is_leap)
);
